// ===== src/ps2mc_pkg.sv =====
package ps2mc_pkg;

    localparam int SIZE_BITS           = 13;
    localparam int OUT_BITS            = 12;
    localparam int COORD_BITS_DEFAULT  = 12;
    localparam int DATA_BITS           = 8;
    localparam int OUT_TDATA_BITS      = 24;

    localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 13'd800;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd600;

    // configuration register indexes
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // sign bits in the first packet byte
    localparam int X_SIGN_BIT = 4;
    localparam int Y_SIGN_BIT = 5;

    typedef enum logic [1:0] {
        PHASE_FIRST,
        PHASE_SECOND,
        PHASE_THIRD
    } byte_phase_t;

endpackage

// ===== src/ps2_mouse_cursor_tracker_core.sv =====
// PS/2 mouse cursor tracker.
// Input stream s_*: one mouse byte per request in s_tdata. Every three bytes
// form a packet; the first carries the X and Y sign bits, the second and third
// the low 8 bits of the 9-bit X and Y movement.
// Output stream m_*: one request per completed packet, carrying the new
// cursor position. X is moved by the packet's X, Y against the packet's Y,
// and each saturates at 0 and at the screen size minus one.
// Configuration: wr_en/wr_index/wr_data write screen_width (index 0) and
// screen_height (index 1); write only while the block is idle.
// Throughput is one byte per cycle while no third byte is held off; the add
// and clamp are combinational and load the cursor registers, which drive
// m_tdata directly. The result appears on the cycle after the third byte is taken.
// Reset clears the byte phase and the cursor to (0, 0), the sizes to 800x600,
// and drops any pending output.
// When the receiver stalls, first and second bytes are still taken; a third
// byte is held off until the pending result has been taken.
module ps2_mouse_cursor_tracker_core #(
    parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic                               wr_index,
    input  logic [ps2mc_pkg::SIZE_BITS-1:0]    wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ps2mc_pkg::DATA_BITS-1:0]    s_tdata,      // [7:0] data_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ps2mc_pkg::OUT_TDATA_BITS-1:0] m_tdata     // [11:0] cursor_x, [23:12] cursor_y
);
    import ps2mc_pkg::*;

    localparam int SW   = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;
    localparam int SUMW = COORD_BITS + 2;

    logic [SIZE_BITS-1:0]  width_reg, height_reg;
    byte_phase_t           phase_reg, phase_next;
    logic [7:0]            b0_reg, b1_reg;
    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  accept;
    logic                  finish;
    logic [COORD_BITS-1:0] top_x, top_y;
    logic signed [SUMW-1:0] sum_x, sum_y;
    logic signed [8:0]     dx, dy;

    function automatic logic [COORD_BITS-1:0] size_top(input logic [SIZE_BITS-1:0] size);
        logic [SW-1:0] ext;
        logic [SW-1:0] lim;
        logic [SW-1:0] dec;
        ext = SW'(size);
        lim = SW'(1) << COORD_BITS;
        dec = ext - SW'(1);
        if (size == '0)
            size_top = '0;
        else if (ext > lim)
            size_top = '1;
        else
            size_top = dec[COORD_BITS-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SUMW-1:0] v,
                                                    input logic [COORD_BITS-1:0] top);
        logic signed [SUMW-1:0] top_s;
        top_s = signed'({2'b00, top});
        if (v < 0)
            clamp = '0;
        else if (v > top_s)
            clamp = top;
        else
            clamp = v[COORD_BITS-1:0];
    endfunction

    // a third byte must not overwrite a result still waiting
    assign s_tready = (phase_reg != PHASE_THIRD) || !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign finish   = accept && (phase_reg == PHASE_THIRD);

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PHASE_FIRST:  phase_next = PHASE_SECOND;
                PHASE_SECOND: phase_next = PHASE_THIRD;
                PHASE_THIRD:  phase_next = PHASE_FIRST;
                default:      phase_next = PHASE_SECOND;
            endcase
        end
    end

    // sign and low byte together form the 9-bit two's complement movement
    assign dx    = signed'({b0_reg[X_SIGN_BIT], b1_reg});
    assign dy    = signed'({b0_reg[Y_SIGN_BIT], s_tdata});
    assign top_x = size_top(width_reg);
    assign top_y = size_top(height_reg);
    assign sum_x = signed'({2'b00, pos_x_reg}) + SUMW'(dx);
    assign sum_y = signed'({2'b00, pos_y_reg}) - SUMW'(dy);

    always_comb
    begin
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (finish)
        begin
            pos_x_next     = clamp(sum_x, top_x);
            pos_y_next     = clamp(sum_y, top_y);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            phase_reg     <= PHASE_FIRST;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_SCREEN_WIDTH:  width_reg  <= wr_data;
                    REG_SCREEN_HEIGHT: height_reg <= wr_data;
                    default:           ;
                endcase
            end
            phase_reg     <= phase_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the first two bytes of the packet
    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == PHASE_SECOND)
            b1_reg <= s_tdata;
        else if (accept && phase_reg != PHASE_THIRD)
            b0_reg <= s_tdata;
    end

    assign m_tvalid = out_valid_reg;

    generate
        if (COORD_BITS >= OUT_BITS)
        begin : g_trunc
            assign m_tdata = {pos_y_reg[OUT_BITS-1:0], pos_x_reg[OUT_BITS-1:0]};
        end
        else
        begin : g_ext
            assign m_tdata = {OUT_BITS'(pos_y_reg), OUT_BITS'(pos_x_reg)};
        end
    endgenerate

endmodule
